### rtl/core/mmf_pkg.sv
// Shared types and constants for the fixed-point matrix multiplier.
// No dependencies; the other files that use it refer to it by scoped names.
package mmf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DIM_REG_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [1:0] {
		FUNC_WR_A = 2'd0,
		FUNC_WR_B = 2'd1,
		FUNC_MUL  = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSPOSE_B = 2'd3;

	typedef struct packed {
		logic clr;
		logic mul_en;
		logic acc_en;
		logic shift;
	} cell_ctrl_t;

endpackage

### rtl/core/mmf_in_if.sv
// Command channel: element writes and compute commands.
// Depends on nothing.
interface mmf_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [2:0]         elem_row;
	logic [2:0]         elem_col;
	logic signed [31:0] elem_value;

	modport source(output valid, func, elem_row, elem_col, elem_value, input ready);
	modport sink(input valid, func, elem_row, elem_col, elem_value, output ready);
endinterface

### rtl/core/mmf_out_if.sv
// Result channel: one beat per product element.
// Depends on nothing.
interface mmf_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         prod_row;
	logic [2:0]         prod_col;
	logic signed [31:0] prod_value;
	logic               saturated;
	logic               last;

	modport source(output valid, prod_row, prod_col, prod_value, saturated, last, input ready);
	modport sink(input valid, prod_row, prod_col, prod_value, saturated, last, output ready);
endinterface

### rtl/core/mmf_cell.sv
// One column cell: registered multiply, wide accumulator, shift to left neighbor.
// Depends on mmf_pkg.
module mmf_cell #(
	parameter int EW = 32,
	parameter int AW = 68
) (
	input  logic                   clk,
	input  mmf_pkg::cell_ctrl_t    ctrl,
	input  logic signed [EW-1:0]   a_val,
	input  logic signed [EW-1:0]   b_val,
	input  logic signed [AW-1:0]   acc_in,
	output logic signed [AW-1:0]   acc_out
);

	logic signed [2*EW-1:0] prod_s2;
	logic signed [AW-1:0]   acc_q;

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s2 <= a_val * b_val;
		end
	end

	always_ff @(posedge clk) begin
		priority if (ctrl.clr) begin
			acc_q <= '0;
		end else if (ctrl.shift) begin
			acc_q <= acc_in;
		end else if (ctrl.acc_en) begin
			acc_q <= acc_q + AW'(prod_s2);
		end
	end

	assign acc_out = acc_q;

endmodule

### rtl/core/matrix_multiply_fixed_unit.sv
// Top level: element stores, sequencer, cell chain and result register.
// Depends on mmf_pkg, mmf_in_if, mmf_out_if and mmf_cell.
//
//  channel | dir | handshake     | payload
//  cmd     | in  | valid/ready   | func, elem_row, elem_col, elem_value
//  res     | out | valid/ready   | prod_row, prod_col, prod_value, saturated, last
//  cfg     | in  | cfg_we only   | cfg_idx, cfg_wdata
//
// A compute command steps, for each output row, through every inner term via the shared A
// read port and the skewed B banks, drains the multiply pipeline, then shifts the chain
// out one column per result beat.
// Reset clears control state only; stores hold whatever was written.
// A stalled result holds the chain; cmd is taken only when the sequencer idles.
module matrix_multiply_fixed_unit #(
	parameter int MAX_DIM    = 8,
	parameter int ELEM_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mmf_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mmf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	mmf_in_if.sink                             cmd,
	mmf_out_if.source                          res
);

	localparam int IW  = $clog2(MAX_DIM);
	localparam int AAW = $clog2(MAX_DIM * MAX_DIM);
	localparam int AW  = 2 * ELEM_WIDTH + $clog2(MAX_DIM) + 1;
	localparam logic [AAW-1:0] DIM_A = AAW'(MAX_DIM);
	localparam logic [IW:0]    DIM_W = (IW + 1)'(MAX_DIM);
	localparam logic signed [AW-1:0] SAT_MAX =
		$signed({{(AW - ELEM_WIDTH + 1){1'b0}}, {(ELEM_WIDTH - 1){1'b1}}});
	localparam logic signed [AW-1:0] SAT_MIN =
		$signed({{(AW - ELEM_WIDTH + 1){1'b1}}, {(ELEM_WIDTH - 1){1'b0}}});

	typedef enum logic [1:0] {ST_IDLE, ST_MAC, ST_FLUSH, ST_EMIT} state_t;

	function automatic logic [IW-1:0] dim_lim(input logic [mmf_pkg::DIM_REG_W-1:0] v);
		logic [IW-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (v > MAX_DIM) begin
			r = IW'(MAX_DIM - 1);
		end else begin
			r = IW'(v - 1'b1);
		end
		return r;
	endfunction

	function automatic logic [IW-1:0] mod_dim(input logic [IW:0] s);
		logic [IW-1:0] r;
		if (s >= DIM_W) begin
			r = IW'(s - DIM_W);
		end else begin
			r = IW'(s);
		end
		return r;
	endfunction

	// configuration
	logic [mmf_pkg::DIM_REG_W-1:0] out_rows_q, inner_len_q, out_cols_q;
	logic                          transpose_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_rows_q    <= 4'd1;
			inner_len_q   <= 4'd1;
			out_cols_q    <= 4'd1;
			transpose_b_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				mmf_pkg::REG_OUT_ROWS:    out_rows_q    <= cfg_wdata;
				mmf_pkg::REG_INNER_LEN:   inner_len_q   <= cfg_wdata;
				mmf_pkg::REG_OUT_COLS:    out_cols_q    <= cfg_wdata;
				mmf_pkg::REG_TRANSPOSE_B: transpose_b_q <= cfg_wdata[0];
			endcase
		end
	end

	// sequencer state
	state_t          state_q;
	logic [IW-1:0]   i_q, k_q, j_q;
	logic [IW-1:0]   rows_lim_q, inner_lim_q, cols_lim_q;
	logic            trans_q;
	logic            v_s1, v_s2;
	logic [IW-1:0]   k_s1;
	logic            res_valid_q;
	logic [IW-1:0]   res_row_q, res_col_q;
	logic [ELEM_WIDTH-1:0] res_val_q;
	logic            res_sat_q, res_last_q;

	logic cmd_acc, wr_ok, emit_load;
	logic [IW-1:0] w_row, w_col, w_bank;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign wr_ok     = (cmd.elem_row < MAX_DIM) && (cmd.elem_col < MAX_DIM);
	assign w_row     = cmd.elem_row[IW-1:0];
	assign w_col     = cmd.elem_col[IW-1:0];
	assign w_bank    = mod_dim((IW + 1)'(w_row) + (IW + 1)'(w_col));
	assign emit_load = (state_q == ST_EMIT) && (!res_valid_q || res.ready);

	// store A
	logic [ELEM_WIDTH-1:0] mem_a [MAX_DIM * MAX_DIM];
	logic [ELEM_WIDTH-1:0] a_rd_s1;
	logic [AAW-1:0]        a_waddr, a_raddr;

	assign a_waddr = AAW'(w_row) * DIM_A + AAW'(w_col);
	assign a_raddr = AAW'(i_q) * DIM_A + AAW'(k_q);

	always_ff @(posedge clk) begin
		if (cmd_acc && wr_ok && cmd.func == mmf_pkg::FUNC_WR_A) begin
			mem_a[a_waddr] <= cmd.elem_value[ELEM_WIDTH-1:0];
		end
		a_rd_s1 <= mem_a[a_raddr];
	end

	// store B: element (r,c) lives in bank (r+c) mod MAX_DIM at row r
	logic [ELEM_WIDTH-1:0] bank_rd_s1 [MAX_DIM];

	for (genvar b = 0; b < MAX_DIM; b++) begin : g_bank
		logic [ELEM_WIDTH-1:0] mem_b [MAX_DIM];
		logic [IW-1:0]         raddr;

		assign raddr = trans_q ? mod_dim((IW + 1)'(b) + DIM_W - (IW + 1)'(k_q)) : k_q;

		always_ff @(posedge clk) begin
			if (cmd_acc && wr_ok && cmd.func == mmf_pkg::FUNC_WR_B && w_bank == IW'(b)) begin
				mem_b[w_row] <= cmd.elem_value[ELEM_WIDTH-1:0];
			end
			bank_rd_s1[b] <= mem_b[raddr];
		end
	end

	// cell chain
	mmf_pkg::cell_ctrl_t   cell_ctrl;
	logic signed [AW-1:0]  cell_acc [MAX_DIM];

	assign cell_ctrl.clr    = (state_q == ST_MAC) && (k_q == '0);
	assign cell_ctrl.mul_en = v_s1;
	assign cell_ctrl.acc_en = v_s2;
	assign cell_ctrl.shift  = emit_load;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		logic signed [AW-1:0] acc_next;
		if (j == MAX_DIM - 1) begin : g_end
			assign acc_next = '0;
		end else begin : g_mid
			assign acc_next = cell_acc[j + 1];
		end
		mmf_cell #(.EW(ELEM_WIDTH), .AW(AW)) u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl),
			.a_val   (a_rd_s1),
			.b_val   (bank_rd_s1[mod_dim((IW + 1)'(k_s1) + (IW + 1)'(j))]),
			.acc_in  (acc_next),
			.acc_out (cell_acc[j])
		);
	end

	// result formatting
	logic signed [AW-1:0]  acc_sh;
	logic                  sat_hi, sat_lo;
	logic [ELEM_WIDTH-1:0] fmt_val;

	assign acc_sh  = cell_acc[0] >>> mmf_pkg::FRAC_BITS;
	assign sat_hi  = acc_sh > SAT_MAX;
	assign sat_lo  = acc_sh < SAT_MIN;
	assign fmt_val = sat_hi ? SAT_MAX[ELEM_WIDTH-1:0] :
	                 sat_lo ? SAT_MIN[ELEM_WIDTH-1:0] : acc_sh[ELEM_WIDTH-1:0];

	always_ff @(posedge clk) begin
		v_s2 <= v_s1;
		k_s1 <= k_q;
		if (emit_load) begin
			res_row_q  <= i_q;
			res_col_q  <= j_q;
			res_val_q  <= fmt_val;
			res_sat_q  <= sat_hi || sat_lo;
			res_last_q <= (i_q == rows_lim_q) && (j_q == cols_lim_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			rows_lim_q  <= '0;
			inner_lim_q <= '0;
			cols_lim_q  <= '0;
			trans_q     <= 1'b0;
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			if (emit_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.func == mmf_pkg::FUNC_MUL) begin
						rows_lim_q  <= dim_lim(out_rows_q);
						inner_lim_q <= dim_lim(inner_len_q);
						cols_lim_q  <= dim_lim(out_cols_q);
						trans_q     <= transpose_b_q;
						i_q         <= '0;
						k_q         <= '0;
						state_q     <= ST_MAC;
					end
				end
				ST_MAC: begin
					if (k_q == inner_lim_q) begin
						state_q <= ST_FLUSH;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (!v_s1 && !v_s2) begin
						j_q     <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						if (j_q != cols_lim_q) begin
							j_q <= j_q + 1'b1;
						end else if (i_q == rows_lim_q) begin
							state_q <= ST_IDLE;
						end else begin
							i_q     <= i_q + 1'b1;
							k_q     <= '0;
							state_q <= ST_MAC;
						end
					end
				end
			endcase
		end
	end

	assign res.valid      = res_valid_q;
	assign res.prod_row   = 3'(res_row_q);
	assign res.prod_col   = 3'(res_col_q);
	assign res.prod_value = 32'(res_val_q);
	assign res.saturated  = res_sat_q;
	assign res.last       = res_last_q;

endmodule

### rtl/core/mmf_checker.sv
// Port-level checks for matrix_multiply_fixed_unit, bound to the top level.
// Depends on mmf_pkg and matrix_multiply_fixed_unit.
module mmf_checker #(
	parameter int ELEM_WIDTH = 32
) (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  cmd_func,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] res_value,
	input logic        res_sat,
	input logic        res_last
);

	// stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_value) && $stable(res_last))
		else $error("result beat changed while stalled");

	a_busy_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_func == mmf_pkg::FUNC_MUL |=> !cmd_ready)
		else $error("command taken during compute");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && !res_valid &&
		(cmd_func == mmf_pkg::FUNC_WR_A || cmd_func == mmf_pkg::FUNC_WR_B) |=> !res_valid)
		else $error("write produced a result");

	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !cmd_ready)
		else $error("ready before final beat");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_sat |->
		res_value[ELEM_WIDTH-2:0] == {(ELEM_WIDTH - 1){~res_value[ELEM_WIDTH-1]}})
		else $error("saturated beat not at a limit");

endmodule

bind matrix_multiply_fixed_unit mmf_checker #(.ELEM_WIDTH(ELEM_WIDTH)) u_mmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_func  (cmd.func),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_value (res.prod_value),
	.res_sat   (res.saturated),
	.res_last  (res.last)
);

### test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for matrix_multiply_fixed_unit: element writes, compute runs,
// register settings and saturation, checked against an in-bench product predictor.
// Depends on mmf_pkg, mmf_in_if, mmf_out_if and the block's RTL.
module tb_top;

	localparam int DIM        = 8;
	localparam int SETTLE     = 64;
	localparam int CYCLE_CAP  = 400000;

	typedef struct {
		logic [2:0]         row;
		logic [2:0]         col;
		logic signed [31:0] value;
		logic               sat;
		logic               last;
	} prod_elem_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mmf_pkg::CFG_IDX_W-1:0]  cfg_idx;
	logic [mmf_pkg::CFG_DATA_W-1:0] cfg_wdata;

	mmf_in_if  cmd_if();
	mmf_out_if res_if();

	matrix_multiply_fixed_unit u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata), .cmd(cmd_if), .res(res_if)
	);

	logic signed [31:0] mat_a [DIM][DIM];
	logic signed [31:0] mat_b [DIM][DIM];
	logic [3:0]         rows_reg, inner_reg, cols_reg;
	logic               trans_reg;
	prod_elem_t         pending_prods[$];

	int  errors, beats_in, beats_out, computes, sat_seen, cycles;
	bit  calm;

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic int eff_dim(input logic [3:0] v);
		if (v == 0) return 1;
		if (v > DIM) return DIM;
		return int'(v);
	endfunction

	function automatic void predict_product();
		int nr, nk, nc;
		logic signed [71:0] acc, sh;
		logic signed [31:0] bv;
		prod_elem_t e;
		nr = eff_dim(rows_reg);
		nk = eff_dim(inner_reg);
		nc = eff_dim(cols_reg);
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				acc = '0;
				for (int k = 0; k < nk; k++) begin
					bv = trans_reg ? mat_b[j][k] : mat_b[k][j];
					acc = acc + 72'(mat_a[i][k]) * 72'(bv);
				end
				sh = acc >>> mmf_pkg::FRAC_BITS;
				e.row = 3'(i);
				e.col = 3'(j);
				e.sat = 1'b0;
				if (sh > 72'sd2147483647) begin
					e.value = 32'h7fffffff;
					e.sat = 1'b1;
				end else if (sh < -72'sd2147483648) begin
					e.value = 32'h80000000;
					e.sat = 1'b1;
				end else begin
					e.value = sh[31:0];
				end
				e.last = (i == nr - 1) && (j == nc - 1);
				pending_prods.push_back(e);
			end
		end
	endfunction

	// one command beat; called and returns at a falling edge
	task automatic send_cmd(input mmf_pkg::func_t f, input logic [2:0] r,
			input logic [2:0] c, input logic [31:0] v);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.func       <= f;
		cmd_if.elem_row   <= r;
		cmd_if.elem_col   <= c;
		cmd_if.elem_value <= v;
		cmd_if.valid      <= 1'b1;
		do @(posedge clk); while (!cmd_if.ready);
		beats_in++;
		case (f)
			mmf_pkg::FUNC_WR_A: mat_a[r][c] = v;
			mmf_pkg::FUNC_WR_B: mat_b[r][c] = v;
			mmf_pkg::FUNC_MUL: begin
				predict_product();
				computes++;
			end
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		while (pending_prods.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// leaves cfg_we high; the caller drops it after the last write
	task automatic write_reg(input logic [mmf_pkg::CFG_IDX_W-1:0] idx, input logic [3:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			mmf_pkg::REG_OUT_ROWS:  rows_reg  = val;
			mmf_pkg::REG_INNER_LEN: inner_reg = val;
			mmf_pkg::REG_OUT_COLS:  cols_reg  = val;
			default:                trans_reg = val[0];
		endcase
	endtask

	task automatic set_shape(input logic [3:0] r, input logic [3:0] k, input logic [3:0] c,
			input logic t);
		wait_idle();
		write_reg(mmf_pkg::REG_OUT_ROWS, r);
		write_reg(mmf_pkg::REG_INNER_LEN, k);
		write_reg(mmf_pkg::REG_OUT_COLS, c);
		write_reg(mmf_pkg::REG_TRANSPOSE_B, {3'b0, t});
		cfg_we <= 1'b0;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h7ffff) - 32'h40000;
			3: return $urandom_range(0, 32'h1ffff) - 32'h10000;
			default: return $urandom;
		endcase
	endfunction

	// result side: random stall before each beat, none while calm
	initial begin
		int n;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			n = calm ? 0 : $urandom_range(0, 10);
			if (n != 0) begin
				res_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		prod_elem_t e;
		if (arst_n && res_if.valid && res_if.ready) begin
			beats_out++;
			if (pending_prods.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				e = pending_prods.pop_front();
				if (res_if.prod_row !== e.row)
					report_mismatch($sformatf("row %0d exp %0d", res_if.prod_row, e.row));
				if (res_if.prod_col !== e.col)
					report_mismatch($sformatf("col %0d exp %0d", res_if.prod_col, e.col));
				if (res_if.prod_value !== e.value)
					report_mismatch($sformatf("(%0d,%0d) value %h exp %h", e.row, e.col,
						res_if.prod_value, e.value));
				if (res_if.saturated !== e.sat)
					report_mismatch($sformatf("(%0d,%0d) sat %b exp %b", e.row, e.col,
						res_if.saturated, e.sat));
				if (res_if.last !== e.last)
					report_mismatch($sformatf("(%0d,%0d) last %b exp %b", e.row, e.col,
						res_if.last, e.last));
				if (e.sat) sat_seen++;
			end
		end
	end

	// every entry written first, so no compute ever reads an unwritten one
	task automatic test_fill_stores();
		calm = 1'b0;
		for (int r = 0; r < DIM; r++)
			for (int c = 0; c < DIM; c++) begin
				send_cmd(mmf_pkg::FUNC_WR_A, 3'(r), 3'(c), pick_value());
				send_cmd(mmf_pkg::FUNC_WR_B, 3'(r), 3'(c), pick_value());
			end
	endtask

	task automatic test_directed();
		calm = 1'b1;
		set_shape(4'd1, 4'd1, 4'd1, 1'b0);
		send_cmd(mmf_pkg::FUNC_WR_A, 3'd0, 3'd0, 32'h00010000);
		send_cmd(mmf_pkg::FUNC_WR_B, 3'd0, 3'd0, 32'hffff0000);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
		// positive and negative overflow
		send_cmd(mmf_pkg::FUNC_WR_A, 3'd0, 3'd0, 32'h7fffffff);
		send_cmd(mmf_pkg::FUNC_WR_B, 3'd0, 3'd0, 32'h7fffffff);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd7, 3'd7, 32'hffffffff);
		send_cmd(mmf_pkg::FUNC_WR_B, 3'd0, 3'd0, 32'h80000000);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
		send_cmd(mmf_pkg::FUNC_WR_A, 3'd0, 3'd0, 32'h80000000);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
		// floor rounding of a tiny negative product
		send_cmd(mmf_pkg::FUNC_WR_A, 3'd0, 3'd0, 32'hffffffff);
		send_cmd(mmf_pkg::FUNC_WR_B, 3'd0, 3'd0, 32'h00000001);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
		send_cmd(mmf_pkg::FUNC_NOP, 3'd7, 3'd7, 32'hffffffff);
		send_cmd(mmf_pkg::FUNC_NOP, 3'd0, 3'd0, 32'h0);
		// zero size acts as one, oversize acts as full
		set_shape(4'd0, 4'd15, 4'd8, 1'b1);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
		set_shape(4'd15, 4'd0, 4'd9, 1'b0);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
		set_shape(4'd8, 4'd8, 4'd8, 1'b0);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
		set_shape(4'd8, 4'd8, 4'd8, 1'b1);
		send_cmd(mmf_pkg::FUNC_MUL, 3'd0, 3'd0, 32'h0);
	endtask

	task automatic test_random_phases();
		int sel;
		for (int ph = 0; ph < 12; ph++) begin
			calm = (ph % 4 == 1);
			if (ph % 3 == 0)
				set_shape(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
					4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
			else
				set_shape(4'($urandom_range(1, 4)), 4'($urandom_range(1, 8)),
					4'($urandom_range(1, 4)), 1'($urandom_range(0, 1)));
			for (int n = 0; n < 18; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < 40)
					send_cmd(mmf_pkg::FUNC_WR_A, 3'($urandom), 3'($urandom), pick_value());
				else if (sel < 80)
					send_cmd(mmf_pkg::FUNC_WR_B, 3'($urandom), 3'($urandom), pick_value());
				else if (sel < 96)
					send_cmd(mmf_pkg::FUNC_MUL, 3'($urandom), 3'($urandom), $urandom);
				else
					send_cmd(mmf_pkg::FUNC_NOP, 3'($urandom), 3'($urandom), $urandom);
			end
			send_cmd(mmf_pkg::FUNC_MUL, 3'($urandom), 3'($urandom), $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_wdata = '0;
		cmd_if.valid = 1'b0;
		cmd_if.func = mmf_pkg::FUNC_NOP;
		cmd_if.elem_row = '0;
		cmd_if.elem_col = '0;
		cmd_if.elem_value = '0;
		rows_reg = 4'd1;
		inner_reg = 4'd1;
		cols_reg = 4'd1;
		trans_reg = 1'b0;
		errors = 0; beats_in = 0; beats_out = 0; computes = 0; sat_seen = 0; cycles = 0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_fill_stores();
		test_directed();
		test_random_phases();
		wait_idle();

		$display("covered %0d command beats, %0d compute runs, %0d product beats (%0d saturated)",
			beats_in, computes, beats_out, sat_seen);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
